// File: rtl/polyphonic_wavetable_synth_macros.svh
// Assertion macros shared by the synthesizer RTL.
`ifndef POLYPHONIC_WAVETABLE_SYNTH_MACROS_SVH
`define POLYPHONIC_WAVETABLE_SYNTH_MACROS_SVH

// Same-cycle implication.
`define PWS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pws_pkg.sv
`default_nettype none

package pws_pkg;

    localparam int PHASE_W      = 24;
    localparam int ENV_W        = 24;
    localparam int SINE_W       = 16;
    localparam int GAIN_W       = 16;
    localparam int CMD_W        = 2;
    localparam int VOICE_W      = 5;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;

    localparam int VOICES_DEFAULT       = 24;
    localparam int SINE_ENTRIES_DEFAULT = 1024;

    localparam int ENV_FULL     = 8388608;
    localparam int CLAMP_LIMIT  = 30000;
    localparam int SAMPLE_SHIFT = 38;
    localparam int PRODUCT_BITS = 38;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [ENV_W-1:0]  ATTACK_RESET  = 24'd47554;
    localparam logic [ENV_W-1:0]  RELEASE_RESET = 24'd1057;
    localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd5400;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INCR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN    = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   code;
        logic [VOICE_W-1:0] voice;
        logic               gate_on;
        logic [PHASE_W-1:0] phase_increment;
    } cmd_word_t;

endpackage

`default_nettype wire

// File: rtl/polyphonic_wavetable_synth.sv
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_stall   | cmd, voice, gate_on, phase_increment
// out     | output    | out_valid / out_stall | sample
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Sample tick: one voice per cycle through the state RAM read,
// envelope/phase update and write-back, sine lookup, multiply and accumulate,
// then the mix is scaled and clamped in the M_HI, M_LO and M_SUM states. Gate
// and increment commands read-modify-write the increment RAM; ignored ones do not.
// Reset clears all voice state at once through per-voice valid bits; no sweep.
// A finished sample waits in the output register under out_stall while the next
// word is taken; a following sample holds in the scaling stage until it frees.
`default_nettype none

module polyphonic_wavetable_synth #(
    parameter int VOICES       = pws_pkg::VOICES_DEFAULT,
    parameter int SINE_ENTRIES = pws_pkg::SINE_ENTRIES_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [pws_pkg::CMD_W-1:0]          cmd,
    input  wire logic [pws_pkg::VOICE_W-1:0]        voice,
    input  wire logic                               gate_on,
    input  wire logic [pws_pkg::PHASE_W-1:0]        phase_increment,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [pws_pkg::SAMPLE_W-1:0]     sample,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pws_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pws_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int MIX_W = pws_pkg::PRODUCT_BITS + 2 + $clog2(VOICES);

    logic [pws_pkg::ENV_W-1:0]  attack_reg;
    logic [pws_pkg::ENV_W-1:0]  release_reg;
    logic [pws_pkg::GAIN_W-1:0] gain_reg;

    pws_pkg::cmd_word_t         cmd_word;
    logic                       unit_idle;
    logic                       in_accept;
    logic signed [MIX_W-1:0]    mix;
    logic                       mix_valid;
    logic                       mix_ready;

    assign cmd_word.code            = cmd;
    assign cmd_word.voice           = voice;
    assign cmd_word.gate_on         = gate_on;
    assign cmd_word.phase_increment = phase_increment;

    assign in_stall  = !unit_idle;
    assign in_accept = in_valid && unit_idle;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= pws_pkg::ATTACK_RESET;
            release_reg <= pws_pkg::RELEASE_RESET;
            gain_reg    <= pws_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pws_pkg::REG_ATTACK:  attack_reg  <= cfg_data;
                pws_pkg::REG_RELEASE: release_reg <= cfg_data;
                pws_pkg::REG_GAIN:    gain_reg    <= cfg_data[pws_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pws_voice_unit #(
        .VOICES       (VOICES),
        .SINE_ENTRIES (SINE_ENTRIES),
        .MIX_W        (MIX_W)
    ) u_voice_unit (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (in_accept),
        .cmd               (cmd_word),
        .attack_increment  (attack_reg),
        .release_increment (release_reg),
        .idle              (unit_idle),
        .mix               (mix),
        .mix_valid         (mix_valid),
        .mix_ready         (mix_ready)
    );

    pws_mix_out #(
        .MIX_W (MIX_W)
    ) u_mix_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .mix         (mix),
        .mix_valid   (mix_valid),
        .mix_ready   (mix_ready),
        .output_gain (gain_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample)
    );

endmodule

`default_nettype wire

// File: rtl/pws_ram.sv
`default_nettype none

module pws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/pws_sine_rom.sv
`default_nettype none

module pws_sine_rom #(
    parameter int SINE_ENTRIES = pws_pkg::SINE_ENTRIES_DEFAULT,
    parameter int SINE_AW      = $clog2(SINE_ENTRIES)
) (
    input  wire logic                        clk,
    input  wire logic [SINE_AW-1:0]          addr,
    output logic signed [pws_pkg::SINE_W-1:0] data
);

    function automatic logic [pws_pkg::SINE_W-1:0] sine_entry(input longint unsigned i);
        longint unsigned t;
        longint unsigned quad;
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        t    = (i << 32) / SINE_ENTRIES;
        quad = (t >> 30) & 64'd3;
        f    = t & ((64'd1 << 30) - 64'd1);
        if (quad[0])
        begin
            f = (64'd1 << 30) - f;
        end
        x    = (f * pws_pkg::HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        pos  = x;
        term = ((x * x2) >> 30) / 64'd6;
        neg  = term;
        term = ((term * x2) >> 30) / 64'd20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd156;
        pos  = pos + term;
        s    = (pos > neg) ? pos - neg : 64'd0;
        s    = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return quad[1] ? pws_pkg::SINE_W'(64'd0 - s) : pws_pkg::SINE_W'(s);
    endfunction

    logic [pws_pkg::SINE_W-1:0] rom_w [SINE_ENTRIES];
    logic [pws_pkg::SINE_W-1:0] data_reg;

    for (genvar g = 0; g < SINE_ENTRIES; g++)
    begin : g_rom
        localparam logic [pws_pkg::SINE_W-1:0] ENTRY = sine_entry(longint'(g));
        assign rom_w[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = $signed(data_reg);

endmodule

`default_nettype wire

// File: rtl/pws_voice_unit.sv
`default_nettype none
`include "polyphonic_wavetable_synth_macros.svh"

module pws_voice_unit #(
    parameter int VOICES       = pws_pkg::VOICES_DEFAULT,
    parameter int SINE_ENTRIES = pws_pkg::SINE_ENTRIES_DEFAULT,
    parameter int MIX_W        = pws_pkg::PRODUCT_BITS + 2 + $clog2(VOICES)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    input  wire pws_pkg::cmd_word_t        cmd,
    input  wire logic [pws_pkg::ENV_W-1:0] attack_increment,
    input  wire logic [pws_pkg::ENV_W-1:0] release_increment,
    output logic                           idle,
    output logic signed [MIX_W-1:0]        mix,
    output logic                           mix_valid,
    input  wire logic                      mix_ready
);

    localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SINE_AW = $clog2(SINE_ENTRIES);
    localparam int PH_W    = pws_pkg::PHASE_W;
    localparam int ENV_W   = pws_pkg::ENV_W;
    localparam int A_W     = ENV_W + PH_W;
    localparam int B_W     = 1 + PH_W;
    localparam int SC_W    = PH_W + SINE_AW;
    localparam int PROD_W  = pws_pkg::SINE_W + ENV_W + 1;

    typedef enum logic [2:0] {S_IDLE, S_CMD_WR, S_SWEEP, S_DRAIN, S_HAND} state_t;

    state_t              state_reg;
    logic [VW-1:0]       idx_reg;
    logic                p1_reg;
    logic                p2_reg;
    logic                p3_reg;
    logic                p1_va_reg;
    logic                p1_vb_reg;
    logic [VOICES-1:0]   valid_a_reg;
    logic [VOICES-1:0]   valid_b_reg;

    pws_pkg::cmd_word_t  cmd_reg;
    logic [VW-1:0]       p1_addr_reg;
    logic [ENV_W-1:0]    p2_env_reg;
    logic signed [PROD_W-1:0] p3_prod_reg;
    logic signed [MIX_W-1:0]  mix_reg;

    logic                a_we;
    logic [VW-1:0]       a_waddr;
    logic [A_W-1:0]      a_wdata;
    logic [VW-1:0]       a_raddr;
    logic [A_W-1:0]      a_rdata;
    logic                b_we;
    logic [VW-1:0]       b_waddr;
    logic [B_W-1:0]      b_wdata;
    logic [VW-1:0]       b_raddr;
    logic [B_W-1:0]      b_rdata;

    logic                start_tick;
    logic                start_wr;
    logic [ENV_W-1:0]    env_cur;
    logic [PH_W-1:0]     phase_cur;
    logic                gate_cur;
    logic [PH_W-1:0]     incr_cur;
    logic [ENV_W:0]      attack_sum;
    logic [ENV_W-1:0]    env_up;
    logic [ENV_W-1:0]    env_down;
    logic [ENV_W-1:0]    env_new;
    logic                active;
    logic [PH_W-1:0]     phase_new;
    logic [SC_W-1:0]     phase_scaled;
    logic [SINE_AW-1:0]  rom_addr;
    logic signed [pws_pkg::SINE_W-1:0] rom_data;
    logic signed [PROD_W-1:0] prod_w;

    assign start_tick = cmd_valid && (state_reg == S_IDLE) && (cmd.code == pws_pkg::CMD_TICK);
    assign start_wr   = cmd_valid && (state_reg == S_IDLE)
                        && ((cmd.code == pws_pkg::CMD_GATE) || (cmd.code == pws_pkg::CMD_INCR))
                        && (int'(cmd.voice) < VOICES);

    assign a_raddr = idx_reg;
    assign b_raddr = (state_reg == S_IDLE) ? VW'(cmd.voice) : idx_reg;

    always_comb
    begin
        env_cur    = p1_va_reg ? a_rdata[A_W-1:PH_W] : '0;
        phase_cur  = p1_va_reg ? a_rdata[PH_W-1:0] : '0;
        gate_cur   = p1_vb_reg & b_rdata[PH_W];
        incr_cur   = p1_vb_reg ? b_rdata[PH_W-1:0] : '0;
        attack_sum = {1'b0, env_cur} + {1'b0, attack_increment};
        env_up     = (attack_sum > (ENV_W + 1)'(pws_pkg::ENV_FULL))
                     ? ENV_W'(pws_pkg::ENV_FULL) : attack_sum[ENV_W-1:0];
        env_down   = (release_increment >= env_cur) ? '0 : env_cur - release_increment;
        env_new    = gate_cur ? env_up : env_down;
        active     = gate_cur || (env_cur != '0);
        phase_new  = phase_cur + incr_cur;
        phase_scaled = {{SINE_AW{1'b0}}, phase_new} * SC_W'(SINE_ENTRIES);
        rom_addr   = phase_scaled[SC_W-1:PH_W];
    end

    assign a_we    = p1_reg && active;
    assign a_waddr = p1_addr_reg;
    assign a_wdata = {env_new, phase_new};

    assign b_we    = (state_reg == S_CMD_WR);
    assign b_waddr = VW'(cmd_reg.voice);
    assign b_wdata = (cmd_reg.code == pws_pkg::CMD_GATE)
                     ? {cmd_reg.gate_on, incr_cur}
                     : {gate_cur, cmd_reg.phase_increment};

    assign prod_w = PROD_W'(rom_data) * PROD_W'($signed({1'b0, p2_env_reg}));

    pws_ram #(.WIDTH(A_W), .DEPTH(VOICES), .AW(VW)) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    pws_ram #(.WIDTH(B_W), .DEPTH(VOICES), .AW(VW)) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    pws_sine_rom #(.SINE_ENTRIES(SINE_ENTRIES), .SINE_AW(SINE_AW)) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            p3_reg      <= 1'b0;
            p1_va_reg   <= 1'b0;
            p1_vb_reg   <= 1'b0;
            valid_a_reg <= '0;
            valid_b_reg <= '0;
        end
        else
        begin
            p1_reg    <= (state_reg == S_SWEEP);
            p2_reg    <= p1_reg;
            p3_reg    <= p2_reg;
            p1_va_reg <= valid_a_reg[a_raddr];
            p1_vb_reg <= valid_b_reg[b_raddr];
            if (a_we)
            begin
                valid_a_reg[a_waddr] <= 1'b1;
            end
            if (b_we)
            begin
                valid_b_reg[b_waddr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start_tick)
                    begin
                        state_reg <= S_SWEEP;
                        idx_reg   <= '0;
                    end
                    else if (start_wr)
                    begin
                        state_reg <= S_CMD_WR;
                    end
                end
                S_CMD_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_SWEEP:
                begin
                    if (idx_reg == VW'(VOICES - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + VW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!p1_reg && !p2_reg && !p3_reg)
                    begin
                        state_reg <= S_HAND;
                    end
                end
                S_HAND:
                begin
                    if (mix_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && (state_reg == S_IDLE))
        begin
            cmd_reg <= cmd;
        end
        p1_addr_reg <= idx_reg;
        p2_env_reg  <= active ? env_new : '0;
        p3_prod_reg <= prod_w;
        if (start_tick)
        begin
            mix_reg <= '0;
        end
        else if (p3_reg)
        begin
            mix_reg <= mix_reg + MIX_W'(p3_prod_reg);
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign mix_valid = (state_reg == S_HAND);
    assign mix       = mix_reg;

    `PWS_ASSERT_IMPL(a_sweep_port_split, clk, rst_n, a_we && (state_reg == S_SWEEP), a_waddr != a_raddr, "voice write-back hits the entry being read")
    `PWS_ASSERT_IMPL(a_hand_drained, clk, rst_n, state_reg == S_HAND, !p1_reg && !p2_reg && !p3_reg, "mix handed off with voices in flight")
    `PWS_ASSERT_IMPL(a_rmw_alone, clk, rst_n, b_we, !p1_reg && !p2_reg && !p3_reg, "command write overlaps a sweep")

endmodule

`default_nettype wire

// File: rtl/pws_mix_out.sv
`default_nettype none
`include "polyphonic_wavetable_synth_macros.svh"

module pws_mix_out #(
    parameter int MIX_W = pws_pkg::PRODUCT_BITS + 2 + $clog2(pws_pkg::VOICES_DEFAULT)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [MIX_W-1:0]       mix,
    input  wire logic                          mix_valid,
    output logic                               mix_ready,
    input  wire logic [pws_pkg::GAIN_W-1:0]    output_gain,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [pws_pkg::SAMPLE_W-1:0] sample
);

    localparam int GAIN_W = pws_pkg::GAIN_W;
    localparam int LO_W   = MIX_W / 2;
    localparam int HI_W   = MIX_W - LO_W;
    localparam int MUL_W  = HI_W;
    localparam int P_W    = MUL_W + GAIN_W;
    localparam int TOT_W  = MIX_W + GAIN_W;
    localparam int SH_W   = TOT_W - pws_pkg::SAMPLE_SHIFT;
    localparam int MAG_W  = pws_pkg::SAMPLE_W - 1;

    typedef enum logic [1:0] {M_IDLE, M_HI, M_LO, M_SUM} state_t;

    state_t                            state_reg;
    logic                              out_valid_reg;
    logic signed [pws_pkg::SAMPLE_W-1:0] sample_reg;
    logic                              neg_reg;
    logic [MIX_W-1:0]                  mag_reg;
    logic [P_W-1:0]                    prod_hi_reg;
    logic [P_W-1:0]                    prod_lo_reg;

    logic [MIX_W-1:0]                  mix_mag;
    logic [MUL_W-1:0]                  mul_a;
    logic [P_W-1:0]                    mul_p;
    logic [TOT_W-1:0]                  total;
    logic [SH_W-1:0]                   shifted;
    logic [MAG_W-1:0]                  mag_c;
    logic signed [pws_pkg::SAMPLE_W-1:0] sample_next;
    logic                              slot_free;

    always_comb
    begin
        mix_mag = mix[MIX_W-1] ? (~$unsigned(mix)) + MIX_W'(1) : $unsigned(mix);
        mul_a   = (state_reg == M_HI) ? mag_reg[MIX_W-1:LO_W] : MUL_W'(mag_reg[LO_W-1:0]);
        mul_p   = {{GAIN_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, output_gain};
        total   = (TOT_W'(prod_hi_reg) << LO_W) + TOT_W'(prod_lo_reg);
        shifted = total[TOT_W-1:pws_pkg::SAMPLE_SHIFT];
        mag_c   = (shifted > SH_W'(pws_pkg::CLAMP_LIMIT))
                  ? MAG_W'(pws_pkg::CLAMP_LIMIT) : shifted[MAG_W-1:0];
        sample_next = neg_reg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= M_IDLE;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
        end
        else
        begin
            if ((state_reg == M_SUM) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                M_IDLE:
                begin
                    if (mix_valid)
                    begin
                        state_reg <= M_HI;
                    end
                end
                M_HI:
                begin
                    state_reg <= M_LO;
                end
                M_LO:
                begin
                    state_reg <= M_SUM;
                end
                M_SUM:
                begin
                    if (slot_free)
                    begin
                        sample_reg    <= sample_next;
                        state_reg     <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == M_IDLE) && mix_valid)
        begin
            neg_reg <= mix[MIX_W-1];
            mag_reg <= mix_mag;
        end
        if (state_reg == M_HI)
        begin
            prod_hi_reg <= mul_p;
        end
        if (state_reg == M_LO)
        begin
            prod_lo_reg <= mul_p;
        end
    end

    assign mix_ready = (state_reg == M_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    `PWS_ASSERT_IMPL(a_sample_range, clk, rst_n, out_valid_reg, (int'(sample_reg) <= pws_pkg::CLAMP_LIMIT) && (int'(sample_reg) >= -pws_pkg::CLAMP_LIMIT), "sample outside clamp range")
    `PWS_ASSERT_NEXT(a_sum_issues, clk, rst_n, (state_reg == M_SUM) && slot_free, out_valid_reg, "finished sample not presented")
    `PWS_ASSERT_NEXT(a_sum_waits, clk, rst_n, (state_reg == M_SUM) && !slot_free, state_reg == M_SUM, "finished sample dropped while output busy")

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOICES       = pws_pkg::VOICES_DEFAULT;
    localparam int SINE_N       = pws_pkg::SINE_ENTRIES_DEFAULT;
    localparam int DRAIN_CYCLES = VOICES + 40;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 92;

    typedef longint unsigned u64_t;

    class mix_predictor;
        bit                 gate_bit [VOICES];
        int unsigned        env_lvl [VOICES];
        logic [pws_pkg::PHASE_W-1:0] phase_acc [VOICES];
        logic [pws_pkg::PHASE_W-1:0] step_tbl [VOICES];
        int                 sine_tbl [SINE_N];
        int unsigned        attack_step;
        int unsigned        release_step;
        int unsigned        gain;
        logic signed [pws_pkg::SAMPLE_W-1:0] expected_samples [$];
        int                 faults;

        function new();
            u64_t t;
            u64_t quad;
            u64_t f;
            u64_t s;
            for (int i = 0; i < SINE_N; i++)
            begin
                t = (u64_t'(i) << 32) / SINE_N;
                quad = (t >> 30) & 64'd3;
                f = t & ((64'd1 << 30) - 64'd1);
                if (quad[0])
                    f = (64'd1 << 30) - f;
                s = taylor_sin((f * pws_pkg::HALF_PI_Q30) >> 30);
                s = (s + (64'd1 << 14)) >> 15;
                if (s > 64'd32767)
                    s = 64'd32767;
                sine_tbl[i] = quad[1] ? -int'(s) : int'(s);
            end
            for (int v = 0; v < VOICES; v++)
            begin
                gate_bit[v] = 1'b0;
                env_lvl[v] = 0;
                phase_acc[v] = '0;
                step_tbl[v] = '0;
            end
            attack_step = 32'(pws_pkg::ATTACK_RESET);
            release_step = 32'(pws_pkg::RELEASE_RESET);
            gain = 32'(pws_pkg::GAIN_RESET);
            faults = 0;
        endfunction

        function u64_t taylor_sin(u64_t x);
            u64_t x2;
            u64_t term;
            u64_t pos;
            u64_t neg;
            x2 = (x * x) >> 30;
            term = x;
            pos = x;
            neg = 0;
            for (int k = 1; k <= 6; k++)
            begin
                term = (term * x2) >> 30;
                term = term / u64_t'((2 * k) * (2 * k + 1));
                if (k % 2)
                    neg += term;
                else
                    pos += term;
            end
            return (pos > neg) ? pos - neg : 64'd0;
        endfunction

        function void write_reg(logic [pws_pkg::CFG_INDEX_W-1:0] idx,
                                logic [pws_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pws_pkg::REG_ATTACK:  attack_step = 32'(data);
                pws_pkg::REG_RELEASE: release_step = 32'(data);
                pws_pkg::REG_GAIN:    gain = 32'(data[pws_pkg::GAIN_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_word(pws_pkg::cmd_word_t w);
            longint mix;
            u64_t mag;
            u64_t idx;
            bit neg;
            int unsigned lvl;
            logic signed [pws_pkg::SAMPLE_W-1:0] result;
            if (w.code == pws_pkg::CMD_GATE || w.code == pws_pkg::CMD_INCR)
            begin
                if (w.voice < VOICES)
                begin
                    if (w.code == pws_pkg::CMD_GATE)
                        gate_bit[w.voice] = w.gate_on;
                    else
                        step_tbl[w.voice] = w.phase_increment;
                end
                return;
            end
            if (w.code != pws_pkg::CMD_TICK)
                return;
            mix = 0;
            for (int v = 0; v < VOICES; v++)
            begin
                if (!gate_bit[v] && env_lvl[v] == 0)
                    continue;
                if (gate_bit[v])
                begin
                    lvl = env_lvl[v] + attack_step;
                    if (lvl > pws_pkg::ENV_FULL)
                        lvl = pws_pkg::ENV_FULL;
                end
                else
                    lvl = (release_step >= env_lvl[v]) ? 0 : env_lvl[v] - release_step;
                env_lvl[v] = lvl;
                phase_acc[v] = phase_acc[v] + step_tbl[v];
                idx = (u64_t'(phase_acc[v]) * SINE_N) >> pws_pkg::PHASE_W;
                if (idx >= SINE_N)
                    idx = u64_t'(SINE_N - 1);
                mix += longint'(sine_tbl[idx]) * longint'(lvl);
            end
            neg = mix < 0;
            mag = neg ? u64_t'(-mix) : u64_t'(mix);
            mag = (mag * gain) >> pws_pkg::SAMPLE_SHIFT;
            if (mag > pws_pkg::CLAMP_LIMIT)
                mag = u64_t'(pws_pkg::CLAMP_LIMIT);
            result = neg ? -$signed(mag[pws_pkg::SAMPLE_W-1:0])
                         : $signed(mag[pws_pkg::SAMPLE_W-1:0]);
            expected_samples.push_back(result);
        endfunction

        function void check_sample(logic signed [pws_pkg::SAMPLE_W-1:0] got);
            logic signed [pws_pkg::SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected sample %0d at %0t", got, $realtime);
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want)
            begin
                faults++;
                if (faults <= 10)
                    $display("sample mismatch at %0t: expected %0d, got %0d",
                             $realtime, want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [pws_pkg::CMD_W-1:0] cmd = pws_pkg::CMD_TICK;
    logic [pws_pkg::VOICE_W-1:0] voice = '0;
    logic gate_on = 1'b0;
    logic [pws_pkg::PHASE_W-1:0] phase_increment = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [pws_pkg::SAMPLE_W-1:0] sample;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pws_pkg::CFG_INDEX_W-1:0] cfg_index = pws_pkg::REG_ATTACK;
    logic [pws_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    mix_predictor predictor = new();
    int burst_left = 0;
    bit hold_pending = 1'b0;

    polyphonic_wavetable_synth uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .voice           (voice),
        .gate_on         (gate_on),
        .phase_increment (phase_increment),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample          (sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            predictor.check_sample(sample);
    end

    initial
    begin : stall_pattern
        int span;
        int pct;
        @(posedge rst_n);
        forever
        begin
            span = $urandom_range(150, 10);
            case ($urandom_range(3))
                0: pct = 0;
                1: pct = 20;
                2: pct = 50;
                default: pct = 80;
            endcase
            repeat (span)
            begin
                @(posedge clk);
                if (hold_pending)
                begin
                    hold_pending = 1'b0;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    task automatic send_word(input logic [pws_pkg::CMD_W-1:0] code,
                             input logic [pws_pkg::VOICE_W-1:0] v,
                             input logic g, input logic [pws_pkg::PHASE_W-1:0] inc);
        pws_pkg::cmd_word_t w;
        int gap;
        w = '{code: code, voice: v, gate_on: g, phase_increment: inc};
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= code;
        voice <= v;
        gate_on <= g;
        phase_increment <= inc;
        do
            @(posedge clk);
        while (in_stall);
        predictor.note_word(w);
    endtask

    task automatic random_items(input int n);
        int counted;
        int r;
        logic [pws_pkg::PHASE_W-1:0] inc;
        counted = 0;
        while (counted < n)
        begin
            r = $urandom_range(99);
            case ($urandom_range(3))
                0: inc = pws_pkg::PHASE_W'($urandom_range(65536));
                1: inc = pws_pkg::PHASE_W'($urandom_range(2048));
                2: inc = pws_pkg::PHASE_W'($urandom);
                default: inc = ($urandom_range(1) == 0) ? '0 : '1;
            endcase
            if (r < 45)
            begin
                send_word(pws_pkg::CMD_TICK, pws_pkg::VOICE_W'($urandom), 1'($urandom),
                          pws_pkg::PHASE_W'($urandom));
                counted++;
            end
            else if (r < 68)
            begin
                send_word(pws_pkg::CMD_GATE, pws_pkg::VOICE_W'($urandom_range(VOICES - 1)),
                          $urandom_range(99) < 55, inc);
                counted++;
            end
            else if (r < 88)
            begin
                send_word(pws_pkg::CMD_INCR, pws_pkg::VOICE_W'($urandom_range(VOICES - 1)),
                          1'($urandom), inc);
                counted++;
            end
            else if (r < 95)
                send_word(($urandom_range(1) == 0) ? pws_pkg::CMD_GATE : pws_pkg::CMD_INCR,
                          pws_pkg::VOICE_W'($urandom_range(31, VOICES)), 1'($urandom), inc);
            else
                send_word(~pws_pkg::CMD_TICK, pws_pkg::VOICE_W'($urandom), 1'($urandom),
                          pws_pkg::PHASE_W'($urandom));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (predictor.expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [pws_pkg::CFG_DATA_W-1:0] attack,
                              input logic [pws_pkg::CFG_DATA_W-1:0] rel,
                              input logic [pws_pkg::CFG_DATA_W-1:0] gain, input bit spare);
        logic [pws_pkg::CFG_INDEX_W-1:0] idx [4];
        logic [pws_pkg::CFG_DATA_W-1:0] data [4];
        int n;
        idx[0] = pws_pkg::REG_ATTACK;
        idx[1] = pws_pkg::REG_RELEASE;
        idx[2] = pws_pkg::REG_GAIN;
        idx[3] = ~pws_pkg::REG_ATTACK;
        data[0] = attack;
        data[1] = rel;
        data[2] = gain;
        data[3] = pws_pkg::CFG_DATA_W'($urandom);
        n = spare ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= data[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            predictor.write_reg(idx[i], data[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [pws_pkg::CFG_DATA_W-1:0] attack_set [PHASES];
        logic [pws_pkg::CFG_DATA_W-1:0] release_set [PHASES];
        logic [pws_pkg::CFG_DATA_W-1:0] gain_set [PHASES];
        attack_set = '{pws_pkg::ATTACK_RESET, 24'd8388608, 24'd1, 24'd0, 24'hFFFFFF,
                       pws_pkg::CFG_DATA_W'($urandom_range(8388608, 1)), 24'd200000};
        release_set = '{pws_pkg::RELEASE_RESET, 24'd8388608, 24'd1, 24'd0, 24'd300000,
                        pws_pkg::CFG_DATA_W'($urandom_range(8388608, 1)), 24'd50000};
        gain_set = '{pws_pkg::CFG_DATA_W'(pws_pkg::GAIN_RESET), 24'd65535, 24'd0, 24'd1,
                     24'hFFFFFF, pws_pkg::CFG_DATA_W'($urandom_range(65535)),
                     pws_pkg::CFG_DATA_W'(pws_pkg::GAIN_RESET)};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(pws_pkg::CMD_TICK, '0, 1'b0, '0);
        send_word(~pws_pkg::CMD_TICK, 5'd31, 1'b1, 24'hFFFFFF);
        send_word(pws_pkg::CMD_GATE, 5'd24, 1'b1, '0);
        send_word(pws_pkg::CMD_INCR, 5'd31, 1'b0, 24'hFFFFFF);
        send_word(pws_pkg::CMD_INCR, 5'd0, 1'b0, 24'hFFFFFF);
        send_word(pws_pkg::CMD_INCR, pws_pkg::VOICE_W'(VOICES - 1), 1'b0, 24'h000001);
        send_word(pws_pkg::CMD_INCR, 5'd10, 1'b1, 24'hAAAAAA);
        send_word(pws_pkg::CMD_INCR, 5'd21, 1'b0, 24'h555555);
        send_word(pws_pkg::CMD_GATE, 5'd0, 1'b1, '0);
        send_word(pws_pkg::CMD_GATE, pws_pkg::VOICE_W'(VOICES - 1), 1'b1, '0);
        send_word(pws_pkg::CMD_GATE, 5'd10, 1'b1, '0);
        send_word(pws_pkg::CMD_GATE, 5'd21, 1'b1, '0);
        repeat (4) send_word(pws_pkg::CMD_TICK, '0, 1'b0, '0);
        send_word(pws_pkg::CMD_GATE, 5'd0, 1'b0, '0);
        send_word(pws_pkg::CMD_TICK, 5'd31, 1'b1, 24'hFFFFFF);
        send_word(pws_pkg::CMD_GATE, pws_pkg::VOICE_W'(VOICES - 1), 1'b0, '0);
        send_word(pws_pkg::CMD_GATE, 5'd10, 1'b0, '0);
        send_word(pws_pkg::CMD_GATE, 5'd21, 1'b0, '0);
        repeat (3) send_word(pws_pkg::CMD_TICK, '0, 1'b0, '0);

        random_items(PHASE_ITEMS);
        drain();

        for (int p = 1; p < PHASES; p++)
        begin
            set_config(attack_set[p], release_set[p], gain_set[p], p == 3);
            if (p == 5)
                hold_pending = 1'b1;
            random_items(PHASE_ITEMS);
            drain();
        end

        if (predictor.faults == 0 && predictor.expected_samples.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
